@@ design/gsr_pkg.sv @@
// Shared types, constants, font table and helper functions of the glyph span renderer.
package gsr_pkg;

   localparam int GLYPH_COLUMNS = 5;
   localparam int GLYPH_ROWS    = 7;
   localparam int MAX_SCALE     = 8;

   localparam int CODE_W   = 8;
   localparam int COORD_W  = 12;
   localparam int SCALE_W  = 4;
   localparam int COLOR_W  = 16;
   localparam int DIM_W    = 12;
   localparam int LINE_Y_W = 11;
   localparam int MASK_W   = 40;

   localparam int ROW_W        = $clog2(GLYPH_ROWS);
   localparam int LINE_W       = $clog2(GLYPH_ROWS * MAX_SCALE);
   localparam int BIT_W        = $clog2(MASK_W + 1);
   localparam int DIGIT_COUNT  = 10;
   localparam int LETTER_COUNT = 26;
   localparam int GLYPH_COUNT  = DIGIT_COUNT + LETTER_COUNT;
   localparam int GIDX_W       = $clog2(GLYPH_COUNT);
   localparam int ROM_ENTRY_W  = GLYPH_ROWS * 8;

   localparam logic [DIM_W-1:0] SCREEN_LIMIT = 12'd2048;
   localparam logic [DIM_W-1:0] SCREEN_RESET = 12'd240;

   localparam logic [CODE_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CODE_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CODE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CODE_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CODE_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CODE_W-1:0] CHAR_LOWER_Z = 8'h7A;

   typedef enum logic [0:0] {
      REG_SCREEN_WIDTH  = 1'b0,
      REG_SCREEN_HEIGHT = 1'b1
   } csr_reg_type;

   typedef logic [GLYPH_COLUMNS-1:0] glyph_row_type;

   typedef struct packed {
      logic              hit;
      logic [GIDX_W-1:0] gidx;
   } glyph_sel_type;

   // One candidate line handed from the sequencer to the raster stages.
   typedef struct packed {
      logic                      hit;
      logic [GIDX_W-1:0]         gidx;
      logic [ROW_W-1:0]          row;
      logic [LINE_W-1:0]         line;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic [SCALE_W-1:0]        scale;
      logic [COLOR_W-1:0]        color;
      logic [BIT_W-1:0]          lo;
      logic [BIT_W-1:0]          hi;
      logic                      last;
   } line_cmd_type;

   typedef struct packed {
      glyph_row_type             row_bits;
      logic [MASK_W-1:0]         clip;
      logic [SCALE_W-1:0]        scale;
      logic [LINE_Y_W-1:0]       line_y;
      logic                      vis;
      logic signed [COORD_W-1:0] x0;
      logic [COLOR_W-1:0]        color;
      logic                      last;
   } line_stage_type;

   typedef struct packed {
      logic                      emit;
      logic                      last;
      logic [LINE_Y_W-1:0]       line_y;
      logic signed [COORD_W-1:0] span_x;
      logic [MASK_W-1:0]         mask;
      logic [COLOR_W-1:0]        color;
   } span_cand_type;

   // Each entry holds seven rows, one byte per row, row zero in the lowest byte.
   localparam logic [ROM_ENTRY_W-1:0] FONT_ROM [GLYPH_COUNT] = '{
      56'h0E11191513110E, 56'h0E04040404_0C04, 56'h1F100806_01110E, 56'h0E110106_01110E,
      56'h02021F120A0602, 56'h0E1101011E101F, 56'h0E11111E100806, 56'h0808080402011F,
      56'h0E11110E11110E, 56'h0C02010F11110E,
      56'h1111111F11110E, 56'h1E11111E11111E, 56'h0E11101010110E, 56'h1E11111111111E,
      56'h1F10101E10101F, 56'h1010101E10101F, 56'h0E111117_10110E, 56'h1111111F111111,
      56'h0E04040404040E, 56'h0C120202020207, 56'h11121418141211, 56'h1F101010101010,
      56'h11111111151B11, 56'h11111315191111, 56'h0E11111111110E, 56'h1010101E11111E,
      56'h0D121511_11110E, 56'h1112141E11111E, 56'h0E11010E10110E, 56'h0404040404041F,
      56'h0E111111111111, 56'h040A1111111111, 56'h111B1515111111, 56'h11110A040A1111,
      56'h04040404_0A1111, 56'h1F10080402011F
   };

   function automatic glyph_sel_type glyph_lookup(logic [CODE_W-1:0] code);
      glyph_sel_type sel;
      sel.hit  = 1'b0;
      sel.gidx = '0;
      if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
         sel.hit  = 1'b1;
         sel.gidx = GIDX_W'(code - CHAR_ZERO);
      end else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
         sel.hit  = 1'b1;
         sel.gidx = GIDX_W'(code - CHAR_LOWER_A) + GIDX_W'(DIGIT_COUNT);
      end else if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
         sel.hit  = 1'b1;
         sel.gidx = GIDX_W'(code - CHAR_UPPER_A) + GIDX_W'(DIGIT_COUNT);
      end
      return sel;
   endfunction

   // Stretches each glyph column over scale mask bits; a zero scale gives an empty row.
   function automatic logic [MASK_W-1:0] expand_row(glyph_row_type bits,
                                                     logic [SCALE_W-1:0] scale);
      logic [MASK_W-1:0] res;
      res = '0;
      for (int k = 1; k <= MAX_SCALE; k++) begin
         if (int'(scale) == k) begin
            for (int c = 0; c < GLYPH_COLUMNS; c++) begin
               for (int t = 0; t < k; t++) begin
                  if (c * k + t < MASK_W) begin
                     res[c * k + t] = bits[c];
                  end
               end
            end
         end
      end
      return res;
   endfunction

endpackage

@@ design/gsr_seq.sv @@
// Request sequencer: takes a request and issues one candidate line per cycle while cmd_ready is high.
module gsr_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gsr_pkg::CODE_W-1:0]        req_char_code,
   input  logic signed [gsr_pkg::COORD_W-1:0] req_x_origin,
   input  logic signed [gsr_pkg::COORD_W-1:0] req_y_origin,
   input  logic [gsr_pkg::SCALE_W-1:0]       req_scale,
   input  logic [gsr_pkg::COLOR_W-1:0]       req_pixel_color,
   input  logic [gsr_pkg::DIM_W-1:0]         screen_width,
   output logic                              cmd_valid,
   input  logic                              cmd_ready,
   output gsr_pkg::line_cmd_type             cmd
);
   import gsr_pkg::*;

   logic                      busy_ff, busy_in;
   line_cmd_type              item_ff, item_in;
   logic [SCALE_W-1:0]        count_ff, count_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic [SCALE_W-1:0]        sub_ff, sub_in;
   logic [LINE_W-1:0]         line_ff, line_in;

   glyph_sel_type             glyph;
   logic [SCALE_W-1:0]        s_sat;
   logic signed [COORD_W:0]   x_ext, neg_x;
   logic signed [COORD_W+1:0] room;
   logic [BIT_W-1:0]          span_w, hi_cap, lo, hi;
   logic                      issue, last_line, accept;

   always_comb begin
      glyph  = glyph_lookup(req_char_code);
      s_sat  = (req_scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : req_scale;
      x_ext  = {req_x_origin[COORD_W-1], req_x_origin};
      neg_x  = -x_ext;
      room   = $signed({2'b00, screen_width}) - $signed({x_ext[COORD_W], x_ext});
      span_w = BIT_W'(GLYPH_COLUMNS * s_sat);
      hi_cap = (span_w > BIT_W'(MASK_W)) ? BIT_W'(MASK_W) : span_w;

      if (!x_ext[COORD_W]) begin
         lo = '0;
      end else if (neg_x > (COORD_W+1)'(MASK_W)) begin
         lo = BIT_W'(MASK_W);
      end else begin
         lo = neg_x[BIT_W-1:0];
      end

      if (room[COORD_W+1] || room == '0) begin
         hi = '0;
      end else if (room < (COORD_W+2)'(hi_cap)) begin
         hi = room[BIT_W-1:0];
      end else begin
         hi = hi_cap;
      end
   end

   always_comb begin
      issue     = busy_ff && cmd_ready;
      last_line = (row_ff == ROW_W'(GLYPH_ROWS - 1)) && (sub_ff == count_ff - SCALE_W'(1));
      req_ready = !busy_ff || (issue && last_line);
      accept    = req_valid && req_ready;

      busy_in  = busy_ff;
      item_in  = item_ff;
      count_in = count_ff;
      row_in   = row_ff;
      sub_in   = sub_ff;
      line_in  = line_ff;

      if (accept) begin
         busy_in       = 1'b1;
         item_in.hit   = glyph.hit;
         item_in.gidx  = glyph.gidx;
         item_in.row   = '0;
         item_in.line  = '0;
         item_in.x0    = req_x_origin;
         item_in.y0    = req_y_origin;
         item_in.scale = s_sat;
         item_in.color = req_pixel_color;
         item_in.lo    = lo;
         item_in.hi    = hi;
         item_in.last  = 1'b0;
         count_in      = (s_sat == '0) ? SCALE_W'(1) : s_sat;
         row_in        = '0;
         sub_in        = '0;
         line_in       = '0;
      end else if (issue) begin
         if (last_line) begin
            busy_in = 1'b0;
         end
         if (sub_ff == count_ff - SCALE_W'(1)) begin
            sub_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            sub_in = sub_ff + SCALE_W'(1);
         end
         line_in = line_ff + LINE_W'(1);
      end

      cmd_valid = busy_ff;
      cmd       = item_ff;
      cmd.row   = row_ff;
      cmd.line  = line_ff;
      cmd.last  = last_line;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      count_ff <= count_in;
      row_ff   <= row_in;
      sub_ff   <= sub_in;
      line_ff  <= line_in;
   end

endmodule

@@ design/gsr_raster.sv @@
// Raster stages: font lookup, clip window and line check, then column expansion.
module gsr_raster (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   output logic                      cmd_ready,
   input  gsr_pkg::line_cmd_type     cmd,
   input  logic [gsr_pkg::DIM_W-1:0] screen_height,
   output logic                      cand_valid,
   input  logic                      cand_ready,
   output gsr_pkg::span_cand_type    cand
);
   import gsr_pkg::*;

   logic                      v2_ff, v2_in, v3_ff, v3_in;
   line_stage_type            s2_ff, s2_in;
   span_cand_type             s3_ff, s3_in;
   logic                      s2_free, s3_free;
   logic [ROM_ENTRY_W-1:0]    entry;
   logic signed [COORD_W:0]   py;
   logic [MASK_W-1:0]         mask;

   always_comb begin
      s3_free   = !v3_ff || cand_ready;
      s2_free   = !v2_ff || s3_free;
      cmd_ready = s2_free;
      v2_in     = s2_free ? cmd_valid : v2_ff;
      v3_in     = s3_free ? v2_ff : v3_ff;
   end

   always_comb begin
      entry = FONT_ROM[cmd.gidx];
      py    = $signed({cmd.y0[COORD_W-1], cmd.y0}) + $signed({1'b0, (COORD_W)'(cmd.line)});
      s2_in = s2_ff;
      if (s2_free && cmd_valid) begin
         s2_in.row_bits = cmd.hit ? entry[{cmd.row, 3'b000} +: GLYPH_COLUMNS] : '0;
         for (int j = 0; j < MASK_W; j++) begin
            s2_in.clip[j] = (BIT_W'(j) >= cmd.lo) && (BIT_W'(j) < cmd.hi);
         end
         s2_in.scale  = cmd.scale;
         s2_in.line_y = py[LINE_Y_W-1:0];
         s2_in.vis    = !py[COORD_W] && (py[COORD_W-1:0] < screen_height);
         s2_in.x0     = cmd.x0;
         s2_in.color  = cmd.color;
         s2_in.last   = cmd.last;
      end
   end

   always_comb begin
      mask  = expand_row(s2_ff.row_bits, s2_ff.scale) & s2_ff.clip;
      s3_in = s3_ff;
      if (s3_free && v2_ff) begin
         s3_in.emit   = s2_ff.vis && (|mask);
         s3_in.last   = s2_ff.last;
         s3_in.line_y = s2_ff.line_y;
         s3_in.span_x = s2_ff.x0;
         s3_in.mask   = mask;
         s3_in.color  = s2_ff.color;
      end
      cand_valid = v3_ff;
      cand       = s3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

endmodule

@@ design/gsr_merge.sv @@
// Span merger: drops empty lines, marks the final span of a request and drives the output register.
module gsr_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cand_valid,
   output logic                                cand_ready,
   input  gsr_pkg::span_cand_type              cand,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gsr_pkg::LINE_Y_W-1:0]        rsp_line_y,
   output logic signed [gsr_pkg::COORD_W-1:0]  rsp_span_x,
   output logic [gsr_pkg::MASK_W-1:0]          rsp_pixel_mask,
   output logic [gsr_pkg::COLOR_W-1:0]         rsp_span_color,
   output logic                                rsp_last_span
);
   import gsr_pkg::*;

   logic          p_valid_ff, p_valid_in, p_last_ff, p_last_in;
   span_cand_type p_ff, p_in;
   logic          rsp_valid_ff, rsp_valid_in;
   span_cand_type out_ff, out_in;
   logic          out_last_ff, out_last_in;
   logic          out_free, take, push;

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_ready;
      cand_ready = out_free;
      take       = cand_valid && out_free;
      push       = out_free && p_valid_ff && (p_last_ff || (cand_valid && cand.emit));

      p_valid_in = p_valid_ff;
      p_last_in  = p_last_ff;
      p_in       = p_ff;
      priority if (take && cand.emit) begin
         p_valid_in = 1'b1;
         p_last_in  = cand.last;
         p_in       = cand;
      end else if (push) begin
         p_valid_in = 1'b0;
         p_last_in  = 1'b0;
      end else if (take && cand.last && p_valid_ff) begin
         p_last_in = 1'b1;
      end

      out_in      = push ? p_ff : out_ff;
      out_last_in = push ? p_last_ff : out_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_valid      = rsp_valid_ff;
      rsp_line_y     = out_ff.line_y;
      rsp_span_x     = out_ff.span_x;
      rsp_pixel_mask = out_ff.mask;
      rsp_span_color = out_ff.color;
      rsp_last_span  = out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         p_last_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= p_valid_in;
         p_last_ff    <= p_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

endmodule

@@ design/glyph_span_renderer_top.sv @@
// Top level of the glyph span renderer: register port, sequencer, raster stages and span merger.
//
//   Channel | Direction | Handshake            | Carries
//   req_    | in        | req_valid/req_ready  | char code, x/y origin, scale, pixel colour
//   rsp_    | out       | rsp_valid/rsp_ready  | line, span x, pixel mask, colour, last flag
//   csr_    | in        | csr_valid/csr_ready  | register index and write data
//
// The output delivers at most one span per cycle. A request makes the sequencer issue 7 * scale
// lines (7 for scale zero, 56 at scale 8 and above), one a cycle while the raster stages accept
// them. A line passes the sequencer, raster stage and merger holding registers to the output
// register; a request's final span leaves the holding register once its last line is resolved.
// Synchronous reset empties every stage and sets both screen registers to 240. req_ready is high
// only while the sequencer is idle or issuing the last line of a request. A low rsp_ready holds
// the output register; the stages behind it fill up and then the sequencer stops issuing lines.
module glyph_span_renderer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gsr_pkg::CODE_W-1:0]          req_char_code,
   input  logic signed [gsr_pkg::COORD_W-1:0]  req_x_origin,
   input  logic signed [gsr_pkg::COORD_W-1:0]  req_y_origin,
   input  logic [gsr_pkg::SCALE_W-1:0]         req_scale,
   input  logic [gsr_pkg::COLOR_W-1:0]         req_pixel_color,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gsr_pkg::LINE_Y_W-1:0]        rsp_line_y,
   output logic signed [gsr_pkg::COORD_W-1:0]  rsp_span_x,
   output logic [gsr_pkg::MASK_W-1:0]          rsp_pixel_mask,
   output logic [gsr_pkg::COLOR_W-1:0]         rsp_span_color,
   output logic                                rsp_last_span,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [0:0]                          csr_index,
   input  logic [gsr_pkg::DIM_W-1:0]           csr_wdata
);
   import gsr_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [DIM_W-1:0] width_eff, height_eff;
   logic             cmd_valid, cmd_ready, cand_valid, cand_ready;
   line_cmd_type     cmd;
   span_cand_type    cand;

   always_comb begin
      csr_ready = 1'b1;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            REG_SCREEN_WIDTH:  width_in  = csr_wdata;
            REG_SCREEN_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
      width_eff  = (width_ff > SCREEN_LIMIT) ? SCREEN_LIMIT : width_ff;
      height_eff = (height_ff > SCREEN_LIMIT) ? SCREEN_LIMIT : height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_RESET;
         height_ff <= SCREEN_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   gsr_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_x_origin    (req_x_origin),
      .req_y_origin    (req_y_origin),
      .req_scale       (req_scale),
      .req_pixel_color (req_pixel_color),
      .screen_width    (width_eff),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd             (cmd)
   );

   gsr_raster u_raster (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd           (cmd),
      .screen_height (height_eff),
      .cand_valid    (cand_valid),
      .cand_ready    (cand_ready),
      .cand          (cand)
   );

   gsr_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .cand_valid     (cand_valid),
      .cand_ready     (cand_ready),
      .cand           (cand),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_line_y     (rsp_line_y),
      .rsp_span_x     (rsp_span_x),
      .rsp_pixel_mask (rsp_pixel_mask),
      .rsp_span_color (rsp_span_color),
      .rsp_last_span  (rsp_last_span)
   );

endmodule

@@ design/gsr_checker.sv @@
// Port checker for the glyph span renderer, bound to the top level.
module gsr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [gsr_pkg::LINE_Y_W-1:0]        rsp_line_y,
   input logic signed [gsr_pkg::COORD_W-1:0]  rsp_span_x,
   input logic [gsr_pkg::MASK_W-1:0]          rsp_pixel_mask,
   input logic [gsr_pkg::COLOR_W-1:0]         rsp_span_color,
   input logic                                rsp_last_span
);
   import gsr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_mask) && $stable(rsp_line_y)
         && $stable(rsp_span_x) && $stable(rsp_span_color) && $stable(rsp_last_span))
      else $error("rsp payload changed while stalled");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn before acceptance");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set straight after reset");

   a_mask_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_mask != '0)
      else $error("span emitted with an empty mask");

   a_left_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_x[COORD_W-1] |-> !rsp_pixel_mask[0])
      else $error("pixel left of the screen left in the mask");

endmodule

bind glyph_span_renderer_top gsr_checker u_gsr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_line_y     (rsp_line_y),
   .rsp_span_x     (rsp_span_x),
   .rsp_pixel_mask (rsp_pixel_mask),
   .rsp_span_color (rsp_span_color),
   .rsp_last_span  (rsp_last_span)
);

@@ test/glyph_span_check_pkg.sv @@
// Scoreboard class that predicts and checks the pixel spans drawn for each glyph request.
package glyph_span_check_pkg;

   import gsr_pkg::*;

   typedef struct {
      logic [LINE_Y_W-1:0]       line_y;
      logic signed [COORD_W-1:0] span_x;
      logic [MASK_W-1:0]         pixel_mask;
      logic [COLOR_W-1:0]        span_color;
      logic                      last_span;
   } glyph_span_type;

   class span_scoreboard;

      glyph_span_type pending_spans[$];
      int unsigned    width_reg;
      int unsigned    height_reg;
      int             mismatches;
      int             spans_seen;

      function new();
         width_reg  = 240;
         height_reg = 240;
         mismatches = 0;
         spans_seen = 0;
      endfunction

      function void set_register(csr_reg_type index, logic [DIM_W-1:0] value);
         if (index == REG_SCREEN_WIDTH) begin
            width_reg = 32'(value);
         end else begin
            height_reg = 32'(value);
         end
      endfunction

      function bit idle();
         return pending_spans.size() == 0;
      endfunction

      // Seven rows per glyph, top row in the most significant byte.
      function logic [55:0] glyph_word(int gidx);
         case (gidx)
            0:  return 56'h0E11131519110E;
            1:  return 56'h040C040404040E;
            2:  return 56'h0E11010608101F;
            3:  return 56'h0E11010601110E;
            4:  return 56'h02060A121F0202;
            5:  return 56'h1F101E0101110E;
            6:  return 56'h0608101E11110E;
            7:  return 56'h1F010204080808;
            8:  return 56'h0E11110E11110E;
            9:  return 56'h0E11110F01020C;
            10: return 56'h0E11111F111111;
            11: return 56'h1E11111E11111E;
            12: return 56'h0E11101010110E;
            13: return 56'h1E11111111111E;
            14: return 56'h1F10101E10101F;
            15: return 56'h1F10101E101010;
            16: return 56'h0E11101711110E;
            17: return 56'h1111111F111111;
            18: return 56'h0E04040404040E;
            19: return 56'h0702020202120C;
            20: return 56'h11121418141211;
            21: return 56'h1010101010101F;
            22: return 56'h111B1511111111;
            23: return 56'h11111915131111;
            24: return 56'h0E11111111110E;
            25: return 56'h1E11111E101010;
            26: return 56'h0E11111115120D;
            27: return 56'h1E11111E141211;
            28: return 56'h0E11100E01110E;
            29: return 56'h1F040404040404;
            30: return 56'h1111111111110E;
            31: return 56'h11111111110A04;
            32: return 56'h11111115151B11;
            33: return 56'h11110A040A1111;
            34: return 56'h11110A04040404;
            35: return 56'h1F01020408101F;
            default: return '0;
         endcase
      endfunction

      function logic [GLYPH_COLUMNS-1:0] glyph_row(logic [CODE_W-1:0] code, int row);
         int          gidx;
         logic [55:0] word;
         if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            gidx = code - CHAR_ZERO;
         end else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
            gidx = DIGIT_COUNT + code - CHAR_LOWER_A;
         end else if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
            gidx = DIGIT_COUNT + code - CHAR_UPPER_A;
         end else begin
            return '0;
         end
         word = glyph_word(gidx);
         return word[8 * (GLYPH_ROWS - 1 - row) +: GLYPH_COLUMNS];
      endfunction

      function void note_request(logic [CODE_W-1:0] code, logic signed [COORD_W-1:0] x0,
                                 logic signed [COORD_W-1:0] y0, logic [SCALE_W-1:0] scale,
                                 logic [COLOR_W-1:0] color);
         int                         s;
         int                         w;
         int                         h;
         int                         xo;
         int                         yo;
         int                         py;
         int                         drawn;
         logic [MASK_W-1:0]          clip;
         logic [MASK_W-1:0]          mask;
         logic [GLYPH_COLUMNS-1:0]   bits;
         glyph_span_type             span;
         s     = (scale > MAX_SCALE) ? MAX_SCALE : int'(scale);
         w     = (width_reg > 2048) ? 2048 : int'(width_reg);
         h     = (height_reg > 2048) ? 2048 : int'(height_reg);
         xo    = x0;
         yo    = y0;
         drawn = 0;
         clip  = '0;
         if (s == 0) begin
            return;
         end
         for (int j = 0; j < GLYPH_COLUMNS * s; j++) begin
            if (xo + j >= 0 && xo + j < w) begin
               clip[j] = 1'b1;
            end
         end
         for (int row = 0; row < GLYPH_ROWS; row++) begin
            bits = glyph_row(code, row);
            mask = '0;
            for (int c = 0; c < GLYPH_COLUMNS; c++) begin
               if (bits[c]) begin
                  for (int k = 0; k < s; k++) begin
                     mask[c * s + k] = 1'b1;
                  end
               end
            end
            mask = mask & clip;
            if (mask != '0) begin
               for (int sy = 0; sy < s; sy++) begin
                  py = yo + row * s + sy;
                  if (py >= 0 && py < h) begin
                     span.line_y     = LINE_Y_W'(py);
                     span.span_x     = x0;
                     span.pixel_mask = mask;
                     span.span_color = color;
                     span.last_span  = 1'b0;
                     pending_spans.push_back(span);
                     drawn++;
                  end
               end
            end
         end
         if (drawn > 0) begin
            pending_spans[pending_spans.size() - 1].last_span = 1'b1;
         end
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         if (mismatches < 40) begin
            $display("span %0d: %s mismatch, got %0h, want %0h", spans_seen, what, got, want);
         end
         mismatches++;
      endtask

      task check_span(logic [LINE_Y_W-1:0] line_y, logic signed [COORD_W-1:0] span_x,
                      logic [MASK_W-1:0] pixel_mask, logic [COLOR_W-1:0] span_color,
                      logic last_span);
         glyph_span_type want;
         if (pending_spans.size() == 0) begin
            report("unexpected span", {53'd0, line_y}, '0);
            spans_seen++;
            return;
         end
         want = pending_spans.pop_front();
         if (line_y !== want.line_y) begin
            report("line_y", 64'(line_y), 64'(want.line_y));
         end
         if (span_x !== want.span_x) begin
            report("span_x", 64'(unsigned'(span_x)), 64'(unsigned'(want.span_x)));
         end
         if (pixel_mask !== want.pixel_mask) begin
            report("pixel_mask", 64'(pixel_mask), 64'(want.pixel_mask));
         end
         if (span_color !== want.span_color) begin
            report("span_color", 64'(span_color), 64'(want.span_color));
         end
         if (last_span !== want.last_span) begin
            report("last_span", 64'(last_span), 64'(want.last_span));
         end
         spans_seen++;
      endtask

      task finish_check();
         if (pending_spans.size() != 0) begin
            report("missing spans", 64'(0), 64'(pending_spans.size()));
         end
      endtask

   endclass

endpackage

@@ test/tb_glyph_span_renderer_top.sv @@
// Testbench of the glyph span renderer with directed and random glyph requests.
module tb_glyph_span_renderer_top;

   timeunit 1ns;
   timeprecision 1ps;

   import gsr_pkg::*;
   import glyph_span_check_pkg::*;

   typedef enum int {
      RX_FLOWING,
      RX_RANDOM,
      RX_BURSTY
   } rx_mode_type;

   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       req_valid       = 1'b0;
   logic                       req_ready;
   logic [CODE_W-1:0]          req_char_code   = '0;
   logic signed [COORD_W-1:0]  req_x_origin    = '0;
   logic signed [COORD_W-1:0]  req_y_origin    = '0;
   logic [SCALE_W-1:0]         req_scale       = '0;
   logic [COLOR_W-1:0]         req_pixel_color = '0;
   logic                       rsp_valid;
   logic                       rsp_ready       = 1'b0;
   logic [LINE_Y_W-1:0]        rsp_line_y;
   logic signed [COORD_W-1:0]  rsp_span_x;
   logic [MASK_W-1:0]          rsp_pixel_mask;
   logic [COLOR_W-1:0]         rsp_span_color;
   logic                       rsp_last_span;
   logic                       csr_valid       = 1'b0;
   logic                       csr_ready;
   logic [0:0]                 csr_index       = '0;
   logic [DIM_W-1:0]           csr_wdata       = '0;

   span_scoreboard board;
   rx_mode_type    rx_mode  = RX_FLOWING;
   int             rx_count = 0;
   int             rx_stall = 0;

   glyph_span_renderer_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_x_origin    (req_x_origin),
      .req_y_origin    (req_y_origin),
      .req_scale       (req_scale),
      .req_pixel_color (req_pixel_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_line_y      (rsp_line_y),
      .rsp_span_x      (rsp_span_x),
      .rsp_pixel_mask  (rsp_pixel_mask),
      .rsp_span_color  (rsp_span_color),
      .rsp_last_span   (rsp_last_span),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (rx_count == 0) begin
         rx_mode  = rx_mode_type'($urandom_range(0, 2));
         rx_count = $urandom_range(20, 150);
      end else begin
         rx_count = rx_count - 1;
      end
      if (rx_stall > 0) begin
         rx_stall = rx_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_FLOWING: begin
               rsp_ready <= 1'b1;
            end
            RX_RANDOM: begin
               rsp_ready <= ($urandom_range(0, 1) == 1);
            end
            default: begin
               if ($urandom_range(0, 15) == 0) begin
                  rx_stall = $urandom_range(4, 20);
               end
               rsp_ready <= 1'b1;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_span(rsp_line_y, rsp_span_x, rsp_pixel_mask, rsp_span_color,
                          rsp_last_span);
      end
   end

   task automatic send_request(input logic [CODE_W-1:0] code, input int x, input int y,
                               input int sc, input logic [COLOR_W-1:0] color);
      logic signed [COORD_W-1:0] xs;
      logic signed [COORD_W-1:0] ys;
      logic [SCALE_W-1:0]        ss;
      xs = COORD_W'(x);
      ys = COORD_W'(y);
      ss = SCALE_W'(sc);
      req_valid       <= 1'b1;
      req_char_code   <= code;
      req_x_origin    <= xs;
      req_y_origin    <= ys;
      req_scale       <= ss;
      req_pixel_color <= color;
      do @(posedge clock); while (!req_ready);
      board.note_request(code, xs, ys, ss, color);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_spans();
      req_valid <= 1'b0;
      @(posedge clock);
      while (!board.idle()) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic write_screen(input int width, input int height);
      csr_valid <= 1'b1;
      csr_index <= REG_SCREEN_WIDTH;
      csr_wdata <= DIM_W'(width);
      do @(posedge clock); while (!csr_ready);
      board.set_register(REG_SCREEN_WIDTH, DIM_W'(width));
      csr_valid <= 1'b1;
      csr_index <= REG_SCREEN_HEIGHT;
      csr_wdata <= DIM_W'(height);
      do @(posedge clock); while (!csr_ready);
      board.set_register(REG_SCREEN_HEIGHT, DIM_W'(height));
      csr_valid <= 1'b0;
   endtask

   task automatic random_request();
      int                r;
      int                x;
      int                y;
      int                sc;
      int                w;
      int                h;
      logic [CODE_W-1:0] code;
      w = (board.width_reg > 2048) ? 2048 : int'(board.width_reg);
      h = (board.height_reg > 2048) ? 2048 : int'(board.height_reg);
      if (w == 0) begin
         w = 1;
      end
      if (h == 0) begin
         h = 1;
      end
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            code = CHAR_ZERO + CODE_W'($urandom_range(0, 9));
         end
         3, 4: begin
            code = CHAR_UPPER_A + CODE_W'($urandom_range(0, 25));
         end
         5, 6: begin
            code = CHAR_LOWER_A + CODE_W'($urandom_range(0, 25));
         end
         default: begin
            code = CODE_W'($urandom_range(0, 255));
         end
      endcase
      r = $urandom_range(0, 9);
      if (r < 6) begin
         sc = $urandom_range(1, 2);
      end else if (r < 9) begin
         sc = $urandom_range(3, 8);
      end else begin
         sc = $urandom_range(0, 15);
      end
      if ($urandom_range(0, 4) == 0) begin
         x = $urandom_range(0, 4095);
      end else begin
         x = int'($urandom_range(0, w + 40)) - 40;
      end
      if ($urandom_range(0, 4) == 0) begin
         y = $urandom_range(0, 4095);
      end else begin
         y = int'($urandom_range(0, h + 56)) - 56;
      end
      send_request(code, x, y, sc, COLOR_W'($urandom_range(0, 65535)));
   endtask

   task automatic random_requests(input int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 8);
         while (burst > 0 && sent < count) begin
            random_request();
            burst--;
            sent++;
         end
         if ($urandom_range(0, 3) != 0) begin
            pause_sender($urandom_range(1, 6));
         end
      end
   endtask

   initial begin
      #2_000_000;
      $display("tb_glyph_span_renderer_top NOT OK");
      $finish;
   end

   initial begin
      int phase_w[9];
      int phase_h[9];
      phase_w = '{0, 240, 1, 2048, 4095, 4095, 0, 0, 0};
      phase_h = '{240, 0, 1, 2048, 4095, 1, 0, 0, 0};
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset screen size: glyph set, scale extremes, blank codes and clipping on all edges.
      send_request("A", 0, 0, 1, 16'hFFFF);
      send_request("z", 10, 10, 8, 16'h0000);
      send_request(CHAR_ZERO, 20, 20, 0, 16'h1234);
      send_request(CHAR_NINE, 30, 30, 15, 16'hA5A5);
      send_request(" ", 40, 40, 3, 16'h5A5A);
      pause_sender(3);
      send_request(8'h00, 0, 0, 2, 16'h0F0F);
      send_request(8'hFF, 0, 0, 2, 16'hF0F0);
      send_request(CHAR_UPPER_Z, 100, 50, 2, 16'h8001);
      send_request(CHAR_LOWER_A, -3, -5, 2, 16'h7FFE);
      send_request("M", 236, 235, 2, 16'h1111);
      send_request("W", -2048, -2048, 8, 16'h2222);
      pause_sender(1);
      send_request("8", 2047, 2047, 8, 16'h3333);
      send_request("Q", -40, 100, 8, 16'h4444);
      send_request("Q", -39, 100, 8, 16'h5555);
      send_request("g", 200, 200, 8, 16'h6666);
      send_request(8'h2F, 50, 50, 1, 16'h7777);
      send_request(8'h3A, 50, 50, 1, 16'h8888);
      send_request(8'h40, 50, 50, 1, 16'h9999);
      send_request(8'h5B, 50, 50, 1, 16'hAAAA);
      send_request(8'h60, 50, 50, 1, 16'hBBBB);
      send_request(8'h7B, 50, 50, 1, 16'hCCCC);
      send_request("k", 120, 60, 4, 16'hDDDD);
      drain_spans();

      for (int p = 0; p < 9; p++) begin
         if (p >= 6) begin
            phase_w[p] = $urandom_range(1, 320);
            phase_h[p] = $urandom_range(1, 320);
         end
         write_screen(phase_w[p], phase_h[p]);
         random_requests(9);
         drain_spans();
      end

      board.finish_check();
      if (board.mismatches == 0) begin
         $display("tb_glyph_span_renderer_top OK");
      end else begin
         $display("tb_glyph_span_renderer_top NOT OK");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/gsr_pkg.sv
design/gsr_seq.sv
design/gsr_raster.sv
design/gsr_merge.sv
design/glyph_span_renderer_top.sv
design/gsr_checker.sv
test/glyph_span_check_pkg.sv
test/tb_glyph_span_renderer_top.sv
